>>> sv/svl_pkg.sv
// ----------------------------------------------------------------------------
// svl_pkg
// Shared types and constants for the sorted value list.
// ----------------------------------------------------------------------------
package svl_pkg;

    localparam int SVL_LIST_DEPTH  = 16;
    localparam int SVL_VALUE_WIDTH = 32;
    localparam int OP_W            = 2;
    localparam int ENTRY_COUNT_W   = 5;
    localparam int M_TDATA_W       = 8;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NOP    = 2'd3
    } t_svl_op;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } t_svl_state;

    typedef struct packed {
        logic capture;
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

>>> sv/svl_cell.sv
// ----------------------------------------------------------------------------
// svl_cell
// One list slot: holds an entry, compares it against the key and shifts
// toward either neighbor on insert or remove.
// ----------------------------------------------------------------------------
module svl_cell
    import svl_pkg::*;
#(
    parameter int LIST_DEPTH  = SVL_LIST_DEPTH,
    parameter int VALUE_WIDTH = SVL_VALUE_WIDTH,
    parameter int CELL_IDX    = 0,
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [VALUE_WIDTH-1:0] i_prev_entry,
    input  logic                   i_prev_le,
    input  logic [VALUE_WIDTH-1:0] i_next_entry,
    output logic [VALUE_WIDTH-1:0] o_entry,
    output logic                   o_le,
    output logic                   o_eq
);

    localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

    logic [VALUE_WIDTH-1:0] r_entry;
    logic [VALUE_WIDTH-1:0] n_entry;
    logic                   r_le;
    logic                   r_lt;
    logic                   w_valid;

    assign w_valid = (IDX < i_count);

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert && !r_le) begin
            n_entry = i_prev_le ? i_key : i_prev_entry;
        end else if (i_ctrl.remove && !r_lt) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctrl.capture) begin
            r_le <= w_valid && ($signed(r_entry) <= $signed(i_key));
            r_lt <= w_valid && ($signed(r_entry) <  $signed(i_key));
        end
    end

    assign o_entry = r_entry;
    assign o_le    = r_le;
    assign o_eq    = r_le && !r_lt;

endmodule

>>> sv/sorted_value_list.sv
// ----------------------------------------------------------------------------
// sorted_value_list
// Bounded ascending list of signed values with insert, remove and search.
// ----------------------------------------------------------------------------
// Usage:
//   Input transactions arrive on s_axis; tdata carries the operation code
//   (insert, remove one copy, search) and the signed value. Every input
//   transaction yields one output transaction on m_axis carrying found,
//   dropped and the entry count after the operation.
//   The list is a row of cells, one per slot. In the accept cycle every cell
//   compares its entry with the value; in the next cycle the cells shift
//   right (insert) or left (remove) in one step and the result is
//   registered. m_axis_tvalid rises when that result is registered, and
//   no new transaction is accepted while the cell row applies the last one.
//   An insert into a full list is dropped and flagged. Duplicates are kept.
//   Reset empties the list; entries hold no value until written.
//   If m_axis_tready is low the result waits in the output register and
//   s_axis_tready stays low until it is taken.
// ----------------------------------------------------------------------------
module sorted_value_list
    import svl_pkg::*;
#(
    parameter int LIST_DEPTH  = SVL_LIST_DEPTH,
    parameter int VALUE_WIDTH = SVL_VALUE_WIDTH,
    localparam int S_TDATA_W  = ((OP_W + VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // operation, value, zero pad
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata   // found, dropped, entry_count, zero pad
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(LIST_DEPTH);

    t_svl_state              r_state;
    t_svl_state              n_state;
    t_svl_op                 r_op;
    logic [VALUE_WIDTH-1:0]  r_key;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic                    r_found;
    logic                    n_found;
    logic                    r_dropped;
    logic                    n_dropped;

    logic                    w_accept;
    logic [VALUE_WIDTH-1:0]  w_key;
    logic                    w_any_eq;
    logic                    w_full;
    t_cell_ctrl              w_ctrl;

    logic [VALUE_WIDTH-1:0]  w_entry [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]   w_le;
    logic [LIST_DEPTH-1:0]   w_eq;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_key         = (r_state == ST_IDLE) ? s_axis_tdata[OP_W +: VALUE_WIDTH] : r_key;
    assign w_any_eq      = |w_eq;
    assign w_full        = (r_count == FULL_CNT);

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_out_valid    = r_out_valid;
        n_found        = r_found;
        n_dropped      = r_dropped;
        w_ctrl.capture = w_accept;
        w_ctrl.insert  = 1'b0;
        w_ctrl.remove  = 1'b0;
        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_APPLY;
                end
            end
            ST_APPLY: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                n_found     = 1'b0;
                n_dropped   = 1'b0;
                unique case (r_op)
                    OP_INSERT: begin
                        if (w_full) begin
                            n_dropped = 1'b1;
                        end else begin
                            w_ctrl.insert = 1'b1;
                            n_count       = r_count + 1'b1;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_any_eq) begin
                            n_found       = 1'b1;
                            w_ctrl.remove = 1'b1;
                            n_count       = r_count - 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        n_found = w_any_eq;
                    end
                    OP_NOP: begin
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found   <= n_found;
        r_dropped <= n_dropped;
        if (w_accept) begin
            r_op  <= t_svl_op'(s_axis_tdata[OP_W-1:0]);
            r_key <= s_axis_tdata[OP_W +: VALUE_WIDTH];
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev_entry;
        logic                   w_prev_le;
        logic [VALUE_WIDTH-1:0] w_next_entry;

        if (g == 0) begin : g_head
            assign w_prev_entry = w_key;
            assign w_prev_le    = 1'b1;
        end else begin : g_body
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_le    = w_le[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[g];
        end else begin : g_inner
            assign w_next_entry = w_entry[g+1];
        end

        svl_cell #(
            .LIST_DEPTH  (LIST_DEPTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .CELL_IDX    (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_key        (w_key),
            .i_count      (r_count),
            .i_prev_entry (w_prev_entry),
            .i_prev_le    (w_prev_le),
            .i_next_entry (w_next_entry),
            .o_entry      (w_entry[g]),
            .o_le         (w_le[g]),
            .o_eq         (w_eq[g])
        );
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - 2 - ENTRY_COUNT_W){1'b0}},
                            ENTRY_COUNT_W'(r_count), r_dropped, r_found};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above list depth");

    a_result_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_APPLY))
        else $error("result raised without an apply cycle");

    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dropped) |-> (r_count == FULL_CNT) && !r_found)
        else $error("dropped insert with room in the list");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_count))
        else $error("count changed outside an apply cycle");

    a_no_accept_in_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPLY) |-> !s_axis_tready)
        else $error("input ready while applying a transaction");

endmodule

>>> bench/sorted_value_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_list_checker
// Watches both stream channels of the sorted value list. Each accepted
// operation is applied to a local copy of the list to predict its result,
// and each accepted result is compared field by field with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module sorted_value_list_checker
    import svl_pkg::*;
#(
    parameter int S_TDATA_W = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,  // operation, value, zero pad
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,  // found, dropped, entry_count, zero pad
    output int                   o_error_count,
    output int                   o_pending_count
);

    typedef struct packed {
        logic                     entry_count_msb_pad;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     dropped;
        logic                     found;
    } t_list_outcome;

    logic signed [SVL_VALUE_WIDTH-1:0] list_entries [SVL_LIST_DEPTH];
    int                                list_count      = 0;
    t_list_outcome                     outcome_q[$];
    int                                mismatch_total  = 0;
    int                                result_index    = 0;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("ERROR @%0t result %0d: %s", $time, result_index, what);
    endtask

    function automatic t_list_outcome apply_list_op(input t_svl_op op,
                                                    input logic signed [SVL_VALUE_WIDTH-1:0] value);
        t_list_outcome res;
        int            pos;
        int            i;
        res = '0;
        pos = 0;
        case (op)
            OP_INSERT: begin
                if (list_count >= SVL_LIST_DEPTH) begin
                    res.dropped = 1'b1;
                end else begin
                    // new copy goes after every equal copy
                    while (pos < list_count && list_entries[pos] <= value) pos++;
                    for (i = list_count; i > pos; i--) list_entries[i] = list_entries[i-1];
                    list_entries[pos] = value;
                    list_count++;
                end
            end
            OP_REMOVE: begin
                while (pos < list_count && list_entries[pos] < value) pos++;
                if (pos < list_count && list_entries[pos] == value) begin
                    res.found = 1'b1;
                    for (i = pos; i < list_count - 1; i++) list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            OP_SEARCH: begin
                while (pos < list_count && list_entries[pos] < value) pos++;
                if (pos < list_count && list_entries[pos] == value) res.found = 1'b1;
            end
            default: begin
            end
        endcase
        res.entry_count = ENTRY_COUNT_W'(list_count);
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_list_outcome got;
        t_list_outcome want;
        if (!i_rst_n) begin
            list_count = 0;
            outcome_q.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                outcome_q.push_back(apply_list_op(t_svl_op'(i_s_tdata[OP_W-1:0]),
                                                  i_s_tdata[OP_W +: SVL_VALUE_WIDTH]));
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (outcome_q.size() == 0) begin
                    report_mismatch("result transaction with no operation pending");
                end else begin
                    want = outcome_q.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  got.found, want.found));
                    if (got.dropped !== want.dropped)
                        report_mismatch($sformatf("dropped %b, expected %b",
                                                  got.dropped, want.dropped));
                    if (got.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count %0d, expected %0d",
                                                  got.entry_count, want.entry_count));
                end
                result_index++;
            end
        end
        o_pending_count <= outcome_q.size();
        o_error_count   <= mismatch_total;
    end

endmodule

>>> bench/sorted_value_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_value_list_tb
// Drives insert, remove, search and unused operations into the sorted value
// list: a directed pass over empty, duplicate, extreme and full-list cases,
// then random fill and drain phases with bursty idling on both channels.
// The checker instance predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module sorted_value_list_tb;
    import svl_pkg::*;

    localparam int S_TDATA_W    = ((OP_W + SVL_VALUE_WIDTH + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 650;
    localparam int QUIET_ITEMS  = 100;
    localparam int PHASE_ITEMS  = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic signed [SVL_VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(SVL_VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [SVL_VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(SVL_VALUE_WIDTH-1){1'b1}}};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic quiet       = 1'b0;
    int   stall_left  = 0;
    int   cycle_count = 0;
    int   error_count;
    int   pending_count;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_value_list dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sorted_value_list_checker #(
        .S_TDATA_W (S_TDATA_W)
    ) checker_inst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_error_count   (error_count),
        .o_pending_count (pending_count)
    );

    // result-side back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left    <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_operation(input t_svl_op op,
                                  input logic signed [SVL_VALUE_WIDTH-1:0] value);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W-OP_W-SVL_VALUE_WIDTH){1'b0}}, value, op};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_svl_op pick_operation(input bit filling);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return OP_NOP;
        if (roll < 15)
            return OP_SEARCH;
        if (filling)
            return (roll < 75) ? OP_INSERT : OP_REMOVE;
        return (roll < 35) ? OP_INSERT : OP_REMOVE;
    endfunction

    // mostly a small pool so removes and searches hit
    function automatic logic signed [SVL_VALUE_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            7, 8, 9: return $urandom;
            default: return int'($urandom_range(0, 6)) - 3;
        endcase
    endfunction

    initial begin : stimulus
        int k;
        int n;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list
        send_operation(OP_SEARCH, 0);
        send_operation(OP_REMOVE, 0);
        send_operation(OP_NOP, -1);
        // extremes and duplicates, with insert below the head
        send_operation(OP_INSERT, VALUE_MAX);
        send_operation(OP_INSERT, VALUE_MIN);
        send_operation(OP_INSERT, 0);
        send_operation(OP_INSERT, 0);
        send_operation(OP_INSERT, -1);
        send_operation(OP_SEARCH, VALUE_MIN);
        send_operation(OP_SEARCH, 5);
        send_operation(OP_REMOVE, 0);
        send_operation(OP_SEARCH, 0);
        send_operation(OP_REMOVE, 12345);
        // fill to capacity, then insert into a full list
        for (k = 0; k < 12; k++) send_operation(OP_INSERT, k * 37 - 200);
        send_operation(OP_INSERT, 99);
        send_operation(OP_NOP, VALUE_MAX);
        send_operation(OP_SEARCH, VALUE_MAX);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            send_operation(pick_operation(((n / PHASE_ITEMS) % 2) == 0), pick_value());
        end
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
